[design/ebfr_pkg.sv]
package ebfr_pkg;

  // Framing bytes on the serial link.
  localparam logic [7:0] BYTE_FLAG = 8'h10;
  localparam logic [7:0] BYTE_ESC  = 8'h1b;

  // Reply codes carried on the result channel.
  localparam logic REPLY_ACK  = 1'b0;
  localparam logic REPLY_NACK = 1'b1;

  // Field widths of the result channel.
  localparam int LEN_W  = 3;
  localparam int DATA_W = 32;
  // Number of payload bytes that fit in the packed data field.
  localparam int OUT_BYTES = DATA_W / 8;

  // Default largest payload of one frame.
  localparam int MAX_PAYLOAD_DEF = 4;

  // Deframer modes; the fourth code is unused and behaves as idle.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_DATA = 2'd1,
    MODE_ESC  = 2'd2
  } mode_t;

  // One result produced by a received byte.
  typedef struct packed {
    logic              valid;
    logic              reply_code;
    logic [LEN_W-1:0]  payload_length;
    logic [DATA_W-1:0] payload_data;
  } result_t;

endpackage

[design/escaped_byte_frame_receiver.sv]
// Byte-stuffed frame receiver.
// The input channel (in_valid, in_ready, in_rx_byte) takes one received
// byte per transaction. A frame opens with the flag byte 0x10 and closes
// with another flag; the escape byte 0x1b makes the next byte literal, and
// that byte must be a flag or an escape. Bytes outside a frame are dropped.
// The result channel (out_valid, out_ready, out_*) gives one transaction
// per closed or broken frame: ACK with the length and the first four
// payload bytes packed low byte first, or NACK with zero length and data
// for an empty frame, an overflow past MAX_PAYLOAD or a bad escape.
// A byte is handled in the cycle it is accepted and its reply appears on
// the output register in the next cycle. One byte is taken every cycle; the
// input stalls only while a reply waits in the output register and the
// receiver holds out_ready low, since the next byte may produce a reply.
// Reset (rst_n low, synchronous) returns the deframer to idle with no
// bytes held and empties the output register.
module escaped_byte_frame_receiver import ebfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_reply_code,
  output logic [LEN_W-1:0]  out_payload_length,
  output logic [DATA_W-1:0] out_payload_data
);

  logic    step;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  logic              reply_code_r;
  logic [LEN_W-1:0]  length_r;
  logic [DATA_W-1:0] data_r;

  // Accept a byte whenever the output register is free or being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  ebfr_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_rx_byte),
    .res     (res)
  );

  // Output register valid flag.
  always_comb begin
    if (step && res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload loads with each new reply.
  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      reply_code_r <= res.reply_code;
      length_r     <= res.payload_length;
      data_r       <= res.payload_data;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reply_code     = reply_code_r;
  assign out_payload_length = length_r;
  assign out_payload_data   = data_r;

endmodule

[design/ebfr_core.sv]
module ebfr_core import ebfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  localparam int CNT_W   = $clog2(MAX_PAYLOAD + 1);
  localparam int STORE_D = (MAX_PAYLOAD < OUT_BYTES) ? MAX_PAYLOAD : OUT_BYTES;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       store_r [STORE_D];
  logic             store_en;
  logic             full;
  logic [DATA_W-1:0] packed_data;

  assign full = (count_r == MAX_CNT);

  // Pack the held bytes, first byte lowest; positions not yet filled read as zero.
  always_comb begin
    packed_data = '0;
    for (int i = 0; i < STORE_D; i++) begin
      if (CNT_W'(i) < count_r) begin
        packed_data[8*i +: 8] = store_r[i];
      end
    end
  end

  // Next mode, byte count and result for the byte at the input.
  always_comb begin
    mode_nxt           = mode_r;
    count_nxt          = count_r;
    store_en           = 1'b0;
    res.valid          = 1'b0;
    res.reply_code     = REPLY_NACK;
    res.payload_length = '0;
    res.payload_data   = '0;
    case (mode_r)
      MODE_DATA: begin
        if (rx_byte == BYTE_ESC) begin
          mode_nxt = MODE_ESC;
        end else if (rx_byte == BYTE_FLAG) begin
          res.valid = 1'b1;
          if (count_r != '0) begin
            res.reply_code     = REPLY_ACK;
            res.payload_length = LEN_W'(count_r);
            res.payload_data   = packed_data;
          end
          mode_nxt  = MODE_IDLE;
          count_nxt = '0;
        end else if (full) begin
          res.valid = 1'b1;
          mode_nxt  = MODE_IDLE;
          count_nxt = '0;
        end else begin
          store_en  = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_ESC: begin
        if ((rx_byte != BYTE_FLAG && rx_byte != BYTE_ESC) || full) begin
          res.valid = 1'b1;
          mode_nxt  = MODE_IDLE;
          count_nxt = '0;
        end else begin
          store_en  = 1'b1;
          count_nxt = count_r + 1'b1;
          mode_nxt  = MODE_DATA;
        end
      end
      default: begin
        if (rx_byte == BYTE_FLAG) begin
          mode_nxt = MODE_DATA;
        end else begin
          mode_nxt = MODE_IDLE;
        end
        count_nxt = '0;
      end
    endcase
  end

  // Mode and count registers advance once per accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      count_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload bytes; only the first few are kept since only those are reported.
  for (genvar g = 0; g < STORE_D; g++) begin : g_store
    always_ff @(posedge clk) begin
      if (step && store_en && count_r == CNT_W'(g)) begin
        store_r[g] <= rx_byte;
      end
    end
  end

  // The byte count never runs past the largest payload.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("byte count exceeds the largest payload");

  // Outside a frame no bytes are held.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDLE |-> count_r == '0)
    else $error("idle with bytes held");

  // Every reply ends the frame.
  a_reply_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid |=> mode_r == MODE_IDLE && count_r == '0)
    else $error("frame not closed after a reply");

endmodule
